// File: design/nfca_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfca_pkg
// shared widths, codes and control structs of the next-fit cell allocator
// ----------------------------------------------------------------------------
package nfca_pkg;

  localparam int INITIAL_CELLS_DEF = 16;
  localparam int MAX_CELLS_DEF     = 4096;

  // bitmap word scanned per memory read
  localparam int WORD_BITS = 32;

  localparam int MODE_W = 2;
  localparam int IDX_W  = 12;
  localparam int STAT_W = 2;
  localparam int SIZE_W = 13;

  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CHECK = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_DEAD = 2'd2;

  typedef struct packed {
    logic clear_step;
    logic accept;
    logic rd;
    logic eval;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic again;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: design/nfca_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfca request and result channels
// valid/ready channels carrying one request or one result item
// ----------------------------------------------------------------------------
interface nfca_in_if;
  logic                        valid;
  logic                        ready;
  logic [nfca_pkg::MODE_W-1:0] mode;
  logic [nfca_pkg::IDX_W-1:0]  cell_index;

  modport source(output valid, output mode, output cell_index, input ready);
  modport sink(input valid, input mode, input cell_index, output ready);
endinterface

interface nfca_out_if;
  logic                        valid;
  logic                        ready;
  logic [nfca_pkg::IDX_W-1:0]  result_index;
  logic [nfca_pkg::STAT_W-1:0] status;
  logic [nfca_pkg::SIZE_W-1:0] pool_size;

  modport source(output valid, output result_index, output status, output pool_size,
                 input ready);
  modport sink(input valid, input result_index, input status, input pool_size,
               output ready);
endinterface
`default_nettype wire

// File: design/nfca_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfca_ctrl
// sequencer: bitmap clear pass, request accept, word read/evaluate loop,
// result hand-off to the output register
// ----------------------------------------------------------------------------
module nfca_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  input  wire nfca_pkg::dp_stat_t   stat,
  output nfca_pkg::ctrl_cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_EVAL,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    in_ready      = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = stat.again ? ST_RD : ST_FIN;
      end
      ST_FIN: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// File: design/nfca_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfca_dp
// used-bit memory, scan pointer, pool size, word scan and result registers
// ----------------------------------------------------------------------------
module nfca_dp #(
  parameter int INITIAL_CELLS = nfca_pkg::INITIAL_CELLS_DEF,
  parameter int MAX_CELLS     = nfca_pkg::MAX_CELLS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire nfca_pkg::ctrl_cmd_t         cmd,
  output nfca_pkg::dp_stat_t               stat,
  input  wire logic [nfca_pkg::MODE_W-1:0] in_mode,
  input  wire logic [nfca_pkg::IDX_W-1:0]  in_cell_index,
  output logic      [nfca_pkg::IDX_W-1:0]  out_result_index,
  output logic      [nfca_pkg::STAT_W-1:0] out_status,
  output logic      [nfca_pkg::SIZE_W-1:0] out_pool_size
);

  localparam int W     = nfca_pkg::WORD_BITS;
  localparam int OFFW  = $clog2(W);
  localparam int STORE = (INITIAL_CELLS > MAX_CELLS) ? INITIAL_CELLS : MAX_CELLS;
  localparam int WORDS = (STORE + W - 1) / W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PW    = $clog2(WORDS * W + 1);
  localparam int IW    = nfca_pkg::IDX_W;
  localparam int CW    = (PW > IW) ? PW : IW;

  logic [W-1:0] mem [WORDS];
  logic [W-1:0] rdata_r;

  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [PW-1:0] ptr_r, ptr_nxt;
  logic [PW-1:0] pool_r, pool_nxt;

  logic [nfca_pkg::MODE_W-1:0] mode_r;
  logic [IW-1:0]               idx_r;
  logic [IW-1:0]               res_r, res_nxt;
  logic [nfca_pkg::STAT_W-1:0] stat_r, stat_nxt;

  // address selection
  logic [CW-1:0] idx_c, pool_c;
  logic [AW-1:0] ptr_word, idx_word, word_addr;
  logic [AW-1:0] wr_addr;
  logic [W-1:0]  wr_data;
  logic          wr_en;

  // scan of one word
  logic            in_range;
  logic [PW-1:0]   base;
  logic [OFFW-1:0] ptr_off;
  logic [PW-1:0]   rem;
  logic [W-1:0]    free_vec;
  logic            found;
  logic [OFFW-1:0] first;
  logic [PW:0]     next_base;
  logic [PW:0]     pool_dbl;
  logic            live;
  logic [OFFW-1:0] idx_off;

  // eval results
  logic [W-1:0] eval_wd;
  logic         eval_we;
  logic         again;

  assign idx_c    = CW'(idx_r);
  assign pool_c   = CW'(pool_r);
  assign ptr_word = ptr_r[OFFW+AW-1:OFFW];
  assign idx_word = idx_c[OFFW+AW-1:OFFW];
  assign word_addr = (mode_r == nfca_pkg::MODE_ALLOC) ? ptr_word : idx_word;

  assign in_range = ptr_r < pool_r;
  assign base     = ptr_r & ~PW'(W - 1);
  assign ptr_off  = ptr_r[OFFW-1:0];
  assign rem      = pool_r - base;
  assign idx_off  = idx_r[OFFW-1:0];
  assign live     = (idx_c < pool_c) && rdata_r[idx_off];
  assign next_base = (PW+1)'(base) + (PW+1)'(W);
  assign pool_dbl  = {pool_r, 1'b0};

  always_comb begin
    for (int j = 0; j < W; j++) begin
      free_vec[j] = in_range && !rdata_r[j] && (OFFW'(j) >= ptr_off) && (PW'(j) < rem);
    end
  end

  // lowest free bit
  always_comb begin
    found = 1'b0;
    first = '0;
    for (int j = W - 1; j >= 0; j--) begin
      if (free_vec[j]) begin
        found = 1'b1;
        first = OFFW'(j);
      end
    end
  end

  always_comb begin
    ptr_nxt  = ptr_r;
    pool_nxt = pool_r;
    res_nxt  = res_r;
    stat_nxt = stat_r;
    eval_we  = 1'b0;
    eval_wd  = rdata_r;
    again    = 1'b0;
    if (cmd.eval) begin
      res_nxt  = idx_r;
      stat_nxt = nfca_pkg::STAT_OK;
      case (mode_r)
        nfca_pkg::MODE_ALLOC: begin
          if (found) begin
            eval_we = 1'b1;
            eval_wd = rdata_r | (W'(1) << first);
            ptr_nxt = base | PW'(first);
            res_nxt = IW'(base | PW'(first));
          end else if (in_range && (next_base < (PW+1)'(pool_r))) begin
            ptr_nxt = next_base[PW-1:0];
            again   = 1'b1;
          end else if (pool_dbl < (PW+1)'(MAX_CELLS)) begin
            // grow the pool and rescan from cell zero
            pool_nxt = pool_dbl[PW-1:0];
            ptr_nxt  = '0;
            again    = 1'b1;
          end else begin
            ptr_nxt  = pool_r;
            res_nxt  = IW'(pool_r - PW'(1));
            stat_nxt = nfca_pkg::STAT_FULL;
          end
        end
        nfca_pkg::MODE_FREE: begin
          if (live) begin
            eval_we = 1'b1;
            eval_wd = rdata_r & ~(W'(1) << idx_off);
          end
        end
        nfca_pkg::MODE_CHECK: begin
          if (!live) begin
            stat_nxt = nfca_pkg::STAT_DEAD;
          end
        end
        default: begin
          stat_nxt = nfca_pkg::STAT_OK;
        end
      endcase
    end
  end

  always_comb begin
    if (cmd.clear_step) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = '0;
    end else begin
      wr_en   = eval_we;
      wr_addr = word_addr;
      wr_data = eval_wd;
    end
  end

  assign clr_addr_nxt = cmd.clear_step ? clr_addr_r + AW'(1) : clr_addr_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rdata_r <= mem[word_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      ptr_r      <= '0;
      pool_r     <= PW'(INITIAL_CELLS);
    end else begin
      clr_addr_r <= clr_addr_nxt;
      ptr_r      <= ptr_nxt;
      pool_r     <= pool_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r <= in_mode;
      idx_r  <= in_cell_index;
    end
    res_r  <= res_nxt;
    stat_r <= stat_nxt;
    if (cmd.load_out) begin
      out_result_index <= res_r;
      out_status       <= stat_r;
      out_pool_size    <= nfca_pkg::SIZE_W'(pool_r);
    end
  end

  assign stat.clear_done = (clr_addr_r == AW'(WORDS - 1));
  assign stat.again      = again;

endmodule
`default_nettype wire

// File: design/next_fit_cell_allocator_core.sv
`default_nettype none
// allocate: the result follows a scan of 32-cell bitmap words from the scan pointer
//   (one memory read and one evaluate per word, pool growth restarts the scan)
// free / check / unused mode: one read and one evaluate of the cell's word before the result
// one request at a time, the next one taken in the cycle after its result is loaded, also while
//   that result still waits at the output
// reset: synchronous clear pass over the used-bit memory, one word a cycle, over
//   ceil(max(INITIAL_CELLS, MAX_CELLS) / 32) words (128 at defaults), no request taken
// ----------------------------------------------------------------------------
// next_fit_cell_allocator_core
// next-fit cell allocator with a used-bit memory and a doubling pool
// ----------------------------------------------------------------------------
module next_fit_cell_allocator_core #(
  parameter int INITIAL_CELLS = nfca_pkg::INITIAL_CELLS_DEF,
  parameter int MAX_CELLS     = nfca_pkg::MAX_CELLS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  nfca_in_if.sink     in_ch,
  nfca_out_if.source  out_ch
);

  nfca_pkg::ctrl_cmd_t cmd;
  nfca_pkg::dp_stat_t  stat;

  nfca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  nfca_dp #(
    .INITIAL_CELLS (INITIAL_CELLS),
    .MAX_CELLS     (MAX_CELLS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_mode          (in_ch.mode),
    .in_cell_index    (in_ch.cell_index),
    .out_result_index (out_ch.result_index),
    .out_status       (out_ch.status),
    .out_pool_size    (out_ch.pool_size)
  );

`ifndef SYNTHESIS
  // no request is taken during the clear pass
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clear_step && in_ch.ready))
    else $error("request ready during clear pass");

  // a result only lands in a free output register
  a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_ch.valid || out_ch.ready))
    else $error("result overwrote a pending output");

  // one request in flight at a time
  a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second request accepted while busy");
`endif

endmodule
`default_nettype wire

// File: dv/tb_next_fit_cell_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_next_fit_cell_allocator_core
// drives allocate, free, check and unused-mode requests through the request
// channel, tracks the used-bit map, scan pointer and pool size in a local
// model, and compares every result field by field; runs directed cases, random
// phases with sender idling and receiver stalls, and one long receiver hold-off
// ----------------------------------------------------------------------------
module tb_next_fit_cell_allocator_core;
  import nfca_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 11;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 320;
  localparam int MAX_REPORTS  = 10;

  localparam int POOL_INIT = INITIAL_CELLS_DEF;
  localparam int POOL_MAX  = MAX_CELLS_DEF;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // two copies of the allocator state: one follows accepted requests,
  // one follows generation so stimulus can aim at live cells
  localparam int SIM_VIEW = 0;
  localparam int GEN_VIEW = 1;

  typedef enum logic [1:0] {PH_NONE, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH} idle_phase_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  cell_index;
  } alloc_request_t;

  typedef struct packed {
    logic [IDX_W-1:0]  result_index;
    logic [STAT_W-1:0] status;
    logic [SIZE_W-1:0] pool_size;
  } alloc_result_t;

  logic clk;
  logic rst_n;

  nfca_in_if  req_ch ();
  nfca_out_if res_ch ();

  next_fit_cell_allocator_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (res_ch)
  );

  bit          cell_map  [2][POOL_MAX];
  int unsigned scan_ptr  [2];
  int unsigned pool_len  [2];

  alloc_request_t request_queue[$];
  alloc_result_t  pending_replies[$];

  idle_phase_t idle_phase;
  int          mismatch_count;
  int          cycle_count;
  bit          hold_go;
  bit          hold_on;
  int          hold_count;

  alloc_request_t next_req;
  alloc_result_t  want;

  always #CLK_HALF clk = ~clk;

  function automatic alloc_result_t step_allocator(input int view,
                                                   input logic [MODE_W-1:0] mode,
                                                   input logic [IDX_W-1:0] idx);
    alloc_result_t r;
    bit            found;
    r.result_index = idx;
    r.status       = STAT_OK;
    found          = 1'b0;
    case (mode)
      MODE_ALLOC: begin
        forever begin
          while (scan_ptr[view] < pool_len[view]) begin
            if (!cell_map[view][scan_ptr[view]]) begin
              cell_map[view][scan_ptr[view]] = 1'b1;
              found = 1'b1;
              break;
            end
            scan_ptr[view]++;
          end
          if (found) begin
            r.result_index = IDX_W'(scan_ptr[view]);
            break;
          end
          if (pool_len[view] * 2 >= POOL_MAX) begin
            r.result_index = IDX_W'(pool_len[view] - 1);
            r.status       = STAT_FULL;
            break;
          end
          // pool grows and the scan restarts from the bottom
          pool_len[view] = pool_len[view] * 2;
          scan_ptr[view] = 0;
        end
      end
      MODE_FREE: begin
        if (idx < pool_len[view] && cell_map[view][idx])
          cell_map[view][idx] = 1'b0;
      end
      MODE_CHECK: begin
        if (!(idx < pool_len[view] && cell_map[view][idx]))
          r.status = STAT_DEAD;
      end
      default: ;
    endcase
    r.pool_size = SIZE_W'(pool_len[view]);
    return r;
  endfunction

  function automatic bit sender_idles();
    case (idle_phase)
      PH_SRC_IDLE: return $urandom_range(0, 99) < 68;
      PH_BOTH:     return $urandom_range(0, 99) < 14;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_phase)
      PH_SNK_STALL: return $urandom_range(0, 99) < 68;
      PH_BOTH:      return $urandom_range(0, 99) < 14;
      default:      return 1'b0;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_live_cell();
    int unsigned c;
    int          t;
    c = 0;
    for (t = 0; t < 8; t++) begin
      c = $urandom_range(0, pool_len[GEN_VIEW] - 1);
      if (cell_map[GEN_VIEW][c])
        break;
    end
    return IDX_W'(c);
  endfunction

  task automatic push_request(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] idx);
    request_queue.push_back(alloc_request_t'{mode: mode, cell_index: idx});
    void'(step_allocator(GEN_VIEW, mode, idx));
  endtask

  task automatic push_random_request();
    int unsigned       r;
    logic [IDX_W-1:0]  idx;
    r   = $urandom_range(0, 99);
    idx = IDX_W'($urandom());
    if (r < 50) begin
      push_request(MODE_ALLOC, idx);
    end else if (r < 75) begin
      if ($urandom_range(0, 3) != 0)
        idx = pick_live_cell();
      push_request(MODE_FREE, idx);
    end else if (r < 92) begin
      case ($urandom_range(0, 3))
        0:       idx = IDX_W'(pool_len[GEN_VIEW]);
        1:       idx = IDX_W'(pool_len[GEN_VIEW] - 1);
        2:       idx = pick_live_cell();
        default: ;
      endcase
      push_request(MODE_CHECK, idx);
    end else begin
      push_request(MODE_UNUSED, idx);
    end
  endtask

  task automatic drain_requests();
    while (request_queue.size() != 0 || req_ch.valid)
      @(negedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (req_ch.valid && req_ch.ready)
        pending_replies.push_back(step_allocator(SIM_VIEW, req_ch.mode, req_ch.cell_index));
      if (!req_ch.valid || req_ch.ready) begin
        if (request_queue.size() != 0 && !sender_idles()) begin
          next_req          = request_queue.pop_front();
          req_ch.valid      <= 1'b1;
          req_ch.mode       <= next_req.mode;
          req_ch.cell_index <= next_req.cell_index;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_replies.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("unexpected result: idx %0d status %0d size %0d",
                   res_ch.result_index, res_ch.status, res_ch.pool_size);
        mismatch_count <= mismatch_count + 1;
      end else begin
        want = pending_replies.pop_front();
        if (res_ch.result_index !== want.result_index || res_ch.status !== want.status ||
            res_ch.pool_size !== want.pool_size) begin
          if (mismatch_count < MAX_REPORTS)
            $display({"result mismatch: want idx %0d status %0d size %0d, ",
                      "got idx %0d status %0d size %0d"},
                     want.result_index, want.status, want.pool_size,
                     res_ch.result_index, res_ch.status, res_ch.pool_size);
          mismatch_count <= mismatch_count + 1;
        end
      end
    end
    res_ch.ready <= rst_n && !hold_on && !receiver_stalls();
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_go) begin
      hold_on    <= 1'b1;
      hold_count <= 0;
    end else if (hold_on) begin
      if (hold_count == HOLD_CYCLES - 1)
        hold_on <= 1'b0;
      hold_count <= hold_count + 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int p;
    int n;
    clk               = 1'b0;
    rst_n             = 1'b0;
    req_ch.valid      = 1'b0;
    req_ch.mode       = MODE_ALLOC;
    req_ch.cell_index = '0;
    res_ch.ready      = 1'b0;
    idle_phase        = PH_NONE;
    mismatch_count    = 0;
    cycle_count       = 0;
    hold_go           = 1'b0;
    hold_on           = 1'b0;
    hold_count        = 0;
    for (p = 0; p < 2; p++) begin
      for (n = 0; n < POOL_MAX; n++)
        cell_map[p][n] = 1'b0;
      scan_ptr[p] = 0;
      pool_len[p] = POOL_INIT;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: dead check, allocation, reuse at the pointer, double free,
    // out-of-pool free and check, unused mode, allocation up to the pool's end, check beyond it
    push_request(MODE_CHECK, 12'd0);
    push_request(MODE_ALLOC, 12'hFFF);
    push_request(MODE_CHECK, 12'd0);
    push_request(MODE_FREE, 12'd0);
    push_request(MODE_ALLOC, 12'd0);
    push_request(MODE_ALLOC, 12'd0);
    push_request(MODE_FREE, 12'd0);
    push_request(MODE_FREE, 12'd0);
    push_request(MODE_ALLOC, 12'hFFF);
    push_request(MODE_FREE, 12'hFFF);
    push_request(MODE_CHECK, 12'hFFF);
    push_request(MODE_UNUSED, 12'hFFF);
    for (n = 0; n < 13; n++)
      push_request(MODE_ALLOC, IDX_W'(n));
    push_request(MODE_CHECK, 12'd31);
    drain_requests();

    for (p = 0; p < 4; p++) begin
      idle_phase = idle_phase_t'(p);
      for (n = 0; n < PHASE_ITEMS; n++)
        push_random_request();
      if (p == 0) begin
        // sender keeps offering while the receiver holds off
        hold_go = 1'b1;
        @(negedge clk);
        hold_go = 1'b0;
      end
      drain_requests();
    end

    idle_phase = PH_BOTH;
    for (n = 0; n < 30; n++)
      push_random_request();
    drain_requests();

    idle_phase = PH_NONE;
    while (pending_replies.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && pending_replies.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
design/nfca_pkg.sv
design/nfca_if.sv
design/nfca_ctrl.sv
design/nfca_dp.sv
design/next_fit_cell_allocator_core.sv
dv/tb_next_fit_cell_allocator_core.sv
